// ----- rtl/odo_pkg.sv -----
// Shared types, widths and constants for the differential-drive odometry block.
// No dependencies; the top level and the CORDIC import this package.
`default_nettype none
package odo_pkg;

  localparam int TICK_W  = 16;
  localparam int CFG_W   = 16;
  localparam int DIST_W  = 33;               // ticks * distance_per_tick
  localparam int SUM_W   = 34;               // dR + dL, dR - dL
  localparam int HEAD_W  = 21;               // stored heading, rad * 2^-16
  localparam int TURN_MAG_W = 20;
  localparam int TRIG_W  = 34;               // CORDIC x/y, Q2.29 with headroom
  localparam int TDIF_W  = TRIG_W + 1;       // sin/cos difference
  localparam int PROD_W  = SUM_W + TDIF_W;   // magnitude product
  localparam int NUM_W   = PROD_W + 1;       // product plus rounding half
  localparam int DEN_W   = 34;
  localparam int DELTA_W = 72;
  localparam int POS_W   = 32;
  localparam int Z_W     = 37;               // CORDIC angle, rad * 2^-30
  localparam int IDX_W   = 5;                // arctangent table index
  localparam int ROUND_SHIFT = 30;

  localparam logic [TURN_MAG_W-1:0] TWO_PI_Q16 = 20'd411775;
  localparam logic signed [Z_W-1:0] PI_Q30      = 37'sd3373259426;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 37'sd6746518852;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 37'sd1686629713;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd326016437;

  localparam logic [CFG_W-1:0] DIST_PER_TICK_RST = 16'd1001;
  localparam logic [CFG_W-1:0] TRACK_WIDTH_RST   = 16'd3610;

  typedef enum logic {
    REG_DIST_PER_TICK = 1'b0,
    REG_TRACK_WIDTH   = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIST_L, ST_DIST_R, ST_TURN, ST_TURN_WAIT, ST_SC0, ST_SC0_WAIT,
    ST_SC1, ST_SC1_WAIT, ST_MUL, ST_MUL_WAIT, ST_DIV, ST_DIV_WAIT, ST_POST, ST_OUT
  } odo_state_t;

  typedef enum logic [1:0] {
    CS_IDLE, CS_REDUCE, CS_ROTATE
  } cordic_state_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/differential_drive_odometry.sv -----
// Differential-drive arc odometry: an item passes the wheel distances, the turn divider, a
// CORDIC run on the start heading and, on an arc, one on the end heading, then per axis the
// multiplier and, on an arc, the divider; each CORDIC run first reduces its angle. One item
// is in flight; s_tready is high only while idle, so a new item is taken only once the last
// result is in the output register, and an output stall holds it off. Synchronous reset
// clears the pose and loads register defaults.
`default_nettype none
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item: [15:0] left_ticks, [31:16] right_ticks
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  // result item: [31:0] x_position, [63:32] y_position, [84:64] heading, [87:85] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import odo_pkg::*;

  odo_state_t state;
  odo_state_t state_next;

  // configuration registers
  logic [CFG_W-1:0] dist_per_tick;
  logic [CFG_W-1:0] track_width;
  reg_index_t       reg_sel;

  // pose
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [HEAD_W-1:0] heading_angle;

  // per-item working registers
  logic signed [TICK_W-1:0]  left_ticks;
  logic signed [TICK_W-1:0]  right_ticks;
  logic signed [DIST_W-1:0]  dist_l;
  logic signed [DIST_W-1:0]  dist_r;
  logic signed [HEAD_W-1:0]  turn;
  logic                      turn_zero;
  logic signed [TRIG_W-1:0]  s0, c0, s1, c1;
  logic                      axis;       // 0: x, 1: y
  logic                      d_neg;
  logic [NUM_W-1:0]          delta_mag;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;

  // datapath helpers
  logic signed [TICK_W-1:0]  tick_sel;
  logic signed [DIST_W-1:0]  dist_prod;
  logic signed [SUM_W-1:0]   dsum;
  logic signed [SUM_W-1:0]   ddiff;
  logic [SUM_W-1:0]          sum_mag;
  logic [SUM_W-1:0]          diff_mag;
  logic [CFG_W-1:0]          tw_eff;
  logic [TURN_MAG_W-1:0]     turn_mag;
  logic [TURN_MAG_W-1:0]     turn_sat;
  logic [DEN_W-1:0]          arc_den;
  logic signed [TDIF_W-1:0]  trig_sel;
  logic [TDIF_W-1:0]         trig_mag;
  logic signed [DELTA_W-1:0] delta_s;
  logic signed [HEAD_W:0]    head_sum;
  logic signed [HEAD_W:0]    head_wrap;
  logic signed [DELTA_W-1:0] x_wide;
  logic signed [DELTA_W-1:0] y_wide;
  logic signed [POS_W-1:0]   x_sat;
  logic signed [POS_W-1:0]   y_sat;
  logic                      out_free;

  // shared unit handshakes
  logic                    mul_start, mul_done;
  logic [PROD_W-1:0]       mul_prod;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic [NUM_W-1:0]        div_quot;
  logic                    cor_start, cor_done;
  logic signed [HEAD_W:0]  cor_angle;
  logic signed [TRIG_W-1:0] cor_sin, cor_cos;

  // ---------------------------------------------------------------- register port
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_DIST_PER_TICK: prdata = {16'b0, dist_per_tick};
      REG_TRACK_WIDTH:   prdata = {16'b0, track_width};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_per_tick <= DIST_PER_TICK_RST;
      track_width   <= TRACK_WIDTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_DIST_PER_TICK: dist_per_tick <= pwdata[CFG_W-1:0];
        REG_TRACK_WIDTH:   track_width   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- arithmetic helpers
  always_comb begin
    tick_sel  = (state == ST_DIST_L) ? left_ticks : right_ticks;
    // signed ticks times unsigned distance; one small multiplier reused for both wheels
    dist_prod = tick_sel * $signed({1'b0, dist_per_tick});
    dsum      = SUM_W'(dist_r) + SUM_W'(dist_l);
    ddiff     = SUM_W'(dist_r) - SUM_W'(dist_l);
    sum_mag   = dsum[SUM_W-1] ? SUM_W'(-dsum) : SUM_W'(dsum);
    diff_mag  = ddiff[SUM_W-1] ? SUM_W'(-ddiff) : SUM_W'(ddiff);
    // a zero track width counts as one
    tw_eff    = (track_width == '0) ? CFG_W'(1) : track_width;
    // saturate the turn to one revolution
    turn_sat  = (div_quot > NUM_W'(TWO_PI_Q16)) ? TWO_PI_Q16 : div_quot[TURN_MAG_W-1:0];
    turn_mag  = turn[HEAD_W-1] ? TURN_MAG_W'(-turn) : TURN_MAG_W'(turn);
    arc_den   = DEN_W'(turn_mag) << 14;

    // straight move uses the start heading; arc move uses the sin/cos difference
    if (turn_zero) begin
      trig_sel = axis ? TDIF_W'(s0) : TDIF_W'(c0);
    end else begin
      trig_sel = axis ? (TDIF_W'(c0) - TDIF_W'(c1)) : (TDIF_W'(s1) - TDIF_W'(s0));
    end
    trig_mag = trig_sel[TDIF_W-1] ? TDIF_W'(-trig_sel) : TDIF_W'(trig_sel);

    delta_s  = d_neg ? -$signed(DELTA_W'(delta_mag)) : $signed(DELTA_W'(delta_mag));

    // heading advance and single wrap by one revolution
    head_sum = {heading_angle[HEAD_W-1], heading_angle} + {turn[HEAD_W-1], turn};
    if (head_sum > $signed({2'b00, TWO_PI_Q16})) begin
      head_wrap = head_sum - $signed({2'b00, TWO_PI_Q16});
    end else if (head_sum < -$signed({2'b00, TWO_PI_Q16})) begin
      head_wrap = head_sum + $signed({2'b00, TWO_PI_Q16});
    end else begin
      head_wrap = head_sum;
    end

    // new position, saturated to 32 bits
    x_wide = {{(DELTA_W-POS_W){pos_x[POS_W-1]}}, pos_x} + dx;
    y_wide = {{(DELTA_W-POS_W){pos_y[POS_W-1]}}, pos_y} + dy;
    if (x_wide > $signed(DELTA_W'(32'h7FFF_FFFF))) begin
      x_sat = 32'sh7FFF_FFFF;
    end else if (x_wide < -$signed(DELTA_W'(33'h0_8000_0000))) begin
      x_sat = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      x_sat = x_wide[POS_W-1:0];
    end
    if (y_wide > $signed(DELTA_W'(32'h7FFF_FFFF))) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (y_wide < -$signed(DELTA_W'(33'h0_8000_0000))) begin
      y_sat = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      y_sat = y_wide[POS_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_DIST_L;
      ST_DIST_L:    state_next = ST_DIST_R;
      ST_DIST_R:    state_next = ST_TURN;
      ST_TURN:      state_next = ST_TURN_WAIT;
      ST_TURN_WAIT: if (div_done) state_next = ST_SC0;
      ST_SC0:       state_next = ST_SC0_WAIT;
      ST_SC0_WAIT:  if (cor_done) state_next = turn_zero ? ST_MUL : ST_SC1;
      ST_SC1:       state_next = ST_SC1_WAIT;
      ST_SC1_WAIT:  if (cor_done) state_next = ST_MUL;
      ST_MUL:       state_next = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (mul_done) state_next = turn_zero ? ST_POST : ST_DIV;
      ST_DIV:       state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_next = ST_POST;
      ST_POST:      state_next = axis ? ST_OUT : ST_MUL;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    mul_start = (state == ST_MUL);
    div_start = (state == ST_TURN) || (state == ST_DIV);
    cor_start = (state == ST_SC0) || (state == ST_SC1);
    cor_angle = (state == ST_SC1) ? head_sum : {heading_angle[HEAD_W-1], heading_angle};
    if (state == ST_TURN) begin
      // round(|dR - dL| * 256 / track), ties away from zero
      div_num = (NUM_W'(diff_mag) << 8) + NUM_W'(tw_eff >> 1);
      div_den = DEN_W'(tw_eff);
    end else begin
      div_num = NUM_W'(mul_prod) + NUM_W'(arc_den >> 1);
      div_den = arc_den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      heading_angle <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        m_tvalid      <= 1'b1;
        pos_x         <= x_sat;
        pos_y         <= y_sat;
        heading_angle <= head_wrap[HEAD_W-1:0];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          left_ticks  <= s_tdata[15:0];
          right_ticks <= s_tdata[31:16];
        end
      end
      ST_DIST_L: dist_l <= dist_prod;
      ST_DIST_R: dist_r <= dist_prod;
      ST_TURN_WAIT: begin
        if (div_done) begin
          turn      <= ddiff[SUM_W-1] ? -$signed(HEAD_W'(turn_sat)) : $signed(HEAD_W'(turn_sat));
          turn_zero <= (turn_sat == '0);
        end
      end
      ST_SC0: axis <= 1'b0;
      ST_SC0_WAIT: begin
        if (cor_done) begin
          s0 <= cor_sin;
          c0 <= cor_cos;
        end
      end
      ST_SC1_WAIT: begin
        if (cor_done) begin
          s1 <= cor_sin;
          c1 <= cor_cos;
        end
      end
      ST_MUL: d_neg <= dsum[SUM_W-1] ^ trig_sel[TDIF_W-1] ^ (turn[HEAD_W-1] && !turn_zero);
      ST_MUL_WAIT: begin
        // straight move: round the product by 2^30 here
        if (mul_done && turn_zero) begin
          delta_mag <= (NUM_W'(mul_prod) + (NUM_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        end
      end
      ST_DIV_WAIT: if (div_done) delta_mag <= div_quot;
      ST_POST: begin
        if (axis) begin
          dy <= delta_s;
        end else begin
          dx <= delta_s;
        end
        axis <= 1'b1;
      end
      default: ;
    endcase
  end

  assign m_tdata = {3'b000, heading_angle, pos_y, pos_x};

  // ---------------------------------------------------------------- shared units
  odo_mul #(.AW(SUM_W), .BW(TDIF_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (sum_mag),
    .b     (trig_mag),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  odo_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .sin_val (cor_sin),
    .cos_val (cor_cos)
  );
endmodule
`default_nettype wire

// ----- rtl/odo_mul.sv -----
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on nothing but the clock and reset.
`default_nettype none
module odo_mul #(
  parameter int AW = 34,
  parameter int BW = 35
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      prod
);
  localparam int PW    = AW + BW;
  localparam int CNT_W = $clog2(BW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PW-1:0]    acc;
  logic [PW-1:0]    a_sh;
  logic [BW-1:0]    b_sh;
  logic             last;

  assign last = (cnt == CNT_W'(BW - 1));
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      acc  <= '0;
      a_sh <= PW'(a);
      b_sh <= b;
      cnt  <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/odo_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
`default_nettype none
module odo_div #(
  parameter int NW = 70,
  parameter int DW = 34
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int CNT_W = $clog2(NW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      rem;
  logic [NW-1:0]    q;
  logic [DW-1:0]    dv;
  logic [DW:0]      rem_sh;
  logic             fits;
  logic             last;

  assign last   = (cnt == CNT_W'(NW - 1));
  assign rem_sh = {rem[DW-1:0], q[NW-1]};
  assign fits   = (rem_sh >= {1'b0, dv});
  assign quot   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      rem <= '0;
      q   <= num;
      dv  <= den;
      cnt <= '0;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dv}) : rem_sh;
      q   <= {q[NW-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/odo_cordic.sv -----
// Iterative rotation-mode CORDIC giving sin and cos of a heading.
// Depends on odo_pkg for widths, angle constants and the arctangent table.
`default_nettype none
module odo_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [odo_pkg::HEAD_W:0]       angle,
  output logic                                       done,
  output logic signed [odo_pkg::TRIG_W-1:0]          sin_val,
  output logic signed [odo_pkg::TRIG_W-1:0]          cos_val
);
  import odo_pkg::*;

  cordic_state_t             state;
  cordic_state_t             state_next;
  logic signed [Z_W-1:0]     z;
  logic signed [TRIG_W-1:0]  x;
  logic signed [TRIG_W-1:0]  y;
  logic signed [TRIG_W-1:0]  xs;
  logic signed [TRIG_W-1:0]  ys;
  logic signed [Z_W-1:0]     step_ang;
  logic [IDX_W-1:0]          cnt;
  logic                      neg;
  logic                      last;
  logic                      in_range;

  assign in_range = !(z > PI_Q30) && !(z < -PI_Q30);

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE:   if (start) state_next = CS_REDUCE;
      CS_REDUCE: if (in_range) state_next = CS_ROTATE;
      CS_ROTATE: if (last) state_next = CS_IDLE;
      default:   state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    last     = (state == CS_ROTATE) && (cnt == IDX_W'(STEPS - 1));
    xs       = x >>> cnt;
    ys       = y >>> cnt;
    step_ang = Z_W'(atan_q30(cnt));
    sin_val  = neg ? -y : y;
    cos_val  = neg ? -x : x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= last;
    end
    case (state)
      CS_IDLE: begin
        if (start) begin
          z   <= {angle[HEAD_W], angle, 14'b0};
          x   <= CORDIC_X0;
          y   <= '0;
          neg <= 1'b0;
          cnt <= '0;
        end
      end
      CS_REDUCE: begin
        if (z > PI_Q30) begin
          z <= z - TWO_PI_Q30;
        end else if (z < -PI_Q30) begin
          z <= z + TWO_PI_Q30;
        end else if (z > HALF_PI_Q30) begin
          z   <= z - PI_Q30;
          neg <= 1'b1;
        end else if (z < -HALF_PI_Q30) begin
          z   <= z + PI_Q30;
          neg <= 1'b1;
        end
      end
      CS_ROTATE: begin
        if (!z[Z_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - step_ang;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + step_ang;
        end
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/odo_checker.sv -----
// Port-level checks for the odometry block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module odo_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [87:0] m_tdata,
  input wire logic        pready
);
  a_out_clear_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result dropped or changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[84:64]) <= 21'sd411775) &&
                 ($signed(m_tdata[84:64]) >= -21'sd411775))
    else $error("heading outside one revolution");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
endmodule

bind differential_drive_odometry odo_checker u_odo_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
`default_nettype wire

// ----- tb/sv/tb_differential_drive_odometry.sv -----
// Testbench for differential_drive_odometry: streams wheel tick pairs, predicts the pose
// with a local arc-odometry model and checks every result item. Depends on odo_pkg and the rtl.
`timescale 1ns / 100ps
module tb_differential_drive_odometry;
  import odo_pkg::*;

  localparam int STEPS = 16;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint TWOPI30 = 64'sd6746518852;
  localparam longint HALFPI30 = 64'sd1686629713;
  localparam longint X0 = 64'sd326016437;
  localparam longint REV = 64'sd411775;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [20:0] hd;
  } pose_t;

  // pending tick pairs and expected poses
  logic [31:0] tick_q[$];
  pose_t pose_q[$];

  // predictor state and register copies
  longint px, py, hang;
  longint dpt, trk;

  int errors = 0;
  int cycles = 0;
  int idle_pct = 22;   // idle chance in percent, zero during quiet stretches
  bit hold_rx = 1'b0;
  int rx_hold_cnt = 0;
  bit hold_tx = 1'b0;

  differential_drive_odometry #(.CORDIC_STEPS(STEPS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rdiv(longint n, longint d);
    longint un, q;
    un = (n < 0) ? -n : n;
    q = (un + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [127:0] rdiv128(logic signed [127:0] n, longint d);
    logic signed [127:0] un, q, dd;
    dd = 128'(signed'(d));
    un = (n < 0) ? -n : n;
    q = (un + dd / 2) / dd;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[32] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767,
      16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};
    return tab[i];
  endfunction

  // CORDIC sine/cosine in Q2.29 of an angle in rad * 2^-16
  task automatic trig(input longint a16, output longint sn, output longint cs);
    longint z, x, y, xs, ys;
    bit flip;
    z = a16 * 16384;
    x = X0;
    y = 0;
    flip = 0;
    while (z > PI30) z -= TWOPI30;
    while (z < -PI30) z += TWOPI30;
    if (z > HALFPI30) begin
      z -= PI30;
      flip = 1;
    end else if (z < -HALFPI30) begin
      z += PI30;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_entry(i);
      end else begin
        x += ys; y -= xs; z += atan_entry(i);
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // advance the predicted pose by one tick pair
  task automatic advance_pose(input logic [31:0] ticks);
    longint dl, dr, tw, sum, turn, s0, c0, s1, c1, dx, dy, den, ds, dc;
    pose_t p;
    dl = longint'($signed(ticks[15:0])) * dpt;
    dr = longint'($signed(ticks[31:16])) * dpt;
    tw = (trk == 0) ? 1 : trk;
    sum = dr + dl;
    turn = rdiv((dr - dl) * 256, tw);
    if (turn > REV) turn = REV;
    if (turn < -REV) turn = -REV;
    trig(hang, s0, c0);
    if (turn == 0) begin
      dx = rdiv(sum * c0, 64'sd1073741824);
      dy = rdiv(sum * s0, 64'sd1073741824);
    end else begin
      trig(hang + turn, s1, c1);
      ds = s1 - s0;
      dc = c0 - c1;
      den = turn * 16384;
      if (den < 0) begin
        den = -den; ds = -ds; dc = -dc;
      end
      // sum*ds can exceed 64 bits in principle; widen to be safe
      dx = longint'(rdiv128(128'(signed'(sum)) * 128'(signed'(ds)), den));
      dy = longint'(rdiv128(128'(signed'(sum)) * 128'(signed'(dc)), den));
      hang += turn;
      if (hang > REV) hang -= REV;
      else if (hang < -REV) hang += REV;
    end
    px = sat(px + dx);
    py = sat(py + dy);
    p.x = px[31:0];
    p.y = py[31:0];
    p.hd = hang[20:0];
    pose_q.push_back(p);
  endtask

  // register write over the APB-style port, setup then access
  task automatic reg_write(input reg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * int'(idx)); pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_DIST_PER_TICK) dpt = val;
    else trk = val;
  endtask

  // wait until the block has drained every item
  task automatic drain;
    while (tick_q.size() != 0 || pose_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // queue one item and predict its pose
  task automatic push_ticks(input logic [15:0] l, input logic [15:0] r);
    tick_q.push_back({r, l});
    advance_pose({r, l});
  endtask

  function automatic logic [15:0] rand_tick(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // random phase: mostly modest ticks, some full range, some straight runs
  task automatic random_phase(input int n);
    logic [15:0] l, r;
    int m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 9);
      l = rand_tick(m < 2 ? 0 : (m < 6 ? 1 : 2));
      r = ($urandom_range(0, 4) == 0) ? l : rand_tick(m < 2 ? 0 : (m < 6 ? 1 : 2));
      push_ticks(l, r);
    end
  endtask

  // driver: offer the head of the pending queue, idle at random
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        void'(tick_q.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (tick_q.size() > 0 && !hold_tx && $urandom_range(0, 99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= tick_q[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // count the cycles of a receiver hold-off
  always @(posedge clk) begin
    if (hold_rx) begin
      rx_hold_cnt <= rx_hold_cnt + 1;
    end else begin
      rx_hold_cnt <= 0;
    end
  end

  // monitor: accept result items and compare against the oldest prediction
  always @(posedge clk) begin
    pose_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pose_q.size() == 0) begin
          $error("result item with no prediction waiting: %h", m_tdata);
          errors++;
        end else begin
          e = pose_q.pop_front();
          if (m_tdata[31:0] !== e.x) begin
            $error("x_position expected %0d got %0d", e.x, $signed(m_tdata[31:0]));
            errors++;
          end
          if (m_tdata[63:32] !== e.y) begin
            $error("y_position expected %0d got %0d", e.y, $signed(m_tdata[63:32]));
            errors++;
          end
          if (m_tdata[84:64] !== e.hd) begin
            $error("heading expected %0d got %0d", e.hd, $signed(m_tdata[84:64]));
            errors++;
          end
        end
      end
      m_tready <= !hold_rx && ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_differential_drive_odometry failed");
      $finish;
    end
  end

  initial begin
    px = 0; py = 0; hang = 0;
    dpt = 1001; trk = 3610;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, straight, opposite spins, huge turn
    push_ticks(16'd0, 16'd0);
    push_ticks(16'd100, 16'd100);
    push_ticks(16'h7fff, 16'h7fff);
    push_ticks(16'h8000, 16'h8000);
    push_ticks(16'h7fff, 16'h8000);
    push_ticks(16'h8000, 16'h7fff);
    push_ticks(16'd10, 16'd50);
    push_ticks(16'hffff, 16'd1);
    push_ticks(16'd1, 16'd2);
    push_ticks(16'h5555, 16'haaaa);
    drain();
    // zero and maximal registers
    reg_write(REG_DIST_PER_TICK, 16'd0);
    reg_write(REG_TRACK_WIDTH, 16'd0);
    push_ticks(16'd300, 16'hff00);
    push_ticks(16'h7fff, 16'h8000);
    drain();
    reg_write(REG_DIST_PER_TICK, 16'hffff);
    reg_write(REG_TRACK_WIDTH, 16'hffff);
    // saturate x by driving straight far
    for (int i = 0; i < 6; i++) push_ticks(16'h7fff, 16'h7fff);
    push_ticks(16'd1, 16'd3);
    push_ticks(16'h8000, 16'h8000);
    drain();

    // random phases over several settings
    reg_write(REG_DIST_PER_TICK, 16'd1001);
    reg_write(REG_TRACK_WIDTH, 16'd3610);
    random_phase(400);
    drain();
    reg_write(REG_DIST_PER_TICK, 16'($urandom_range(1, 65535)));
    reg_write(REG_TRACK_WIDTH, 16'($urandom_range(1, 65535)));
    // quiet stretch with no idling
    idle_pct = 0;
    random_phase(300);
    drain();
    idle_pct = 22;
    // long receiver hold-off while items keep coming
    hold_rx = 1'b1;
    random_phase(300);
    wait (rx_hold_cnt >= 3000);
    hold_rx = 1'b0;
    drain();
    // sender pauses until everything has come back, then resumes
    hold_tx = 1'b1;
    drain();
    hold_tx = 1'b0;
    reg_write(REG_DIST_PER_TICK, 16'd1);
    reg_write(REG_TRACK_WIDTH, 16'd1);
    random_phase(250);
    drain();
    reg_write(REG_DIST_PER_TICK, 16'($urandom));
    reg_write(REG_TRACK_WIDTH, 16'($urandom_range(200, 20000)));
    random_phase(350);
    drain();

    if (errors == 0) begin
      $display("tb_differential_drive_odometry passed");
    end else begin
      $display("tb_differential_drive_odometry failed");
    end
    $finish;
  end

endmodule

// ----- differential_drive_odometry.f -----
rtl/odo_pkg.sv
rtl/odo_mul.sv
rtl/odo_div.sv
rtl/odo_cordic.sv
rtl/differential_drive_odometry.sv
rtl/odo_checker.sv
tb/sv/tb_differential_drive_odometry.sv
